### hw/rtl/drrhe_pkg.sv
// Shared constants, codes and types for the decimal rescale block.
package drrhe_pkg;

   // Default mantissa width at the input
   localparam int DEFAULT_IN_BITS = 224;

   // Largest scale that an ok result may carry
   localparam logic [7:0] MAX_SCALE = 8'd28;

   // Width of the result mantissa
   localparam int OUT_BITS = 96;

   // Limb width of the divide-by-ten unit
   localparam int LIMB_BITS = 32;

   // Divide by ten of a 33-bit value: q = (n * RECIP_TEN) >> RECIP_SHIFT
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // 2^32 = 10 * LIMB_QUOT + LIMB_REM
   localparam logic [31:0] LIMB_QUOT = 32'd429496729;
   localparam logic [3:0]  LIMB_REM  = 4'd6;

   // Round digit at the halfway point
   localparam logic [3:0] HALF_DIGIT = 4'd5;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_TOO_SMALL = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_COUNT  = 7'b0000010,
      S_DIV    = 7'b0000100,
      S_REDUCE = 7'b0001000,
      S_ROUND  = 7'b0010000,
      S_FIX    = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

endpackage

### hw/rtl/decimal_rescale_round_half_even.sv
// Top level: rescale a wide decimal mantissa to 96 bits, rounding half to even.
//
// Usage
//   Input channel req_*: a mantissa of up to IN_BITS bits in four words and a
//   decimal scale. A word is taken when req_valid is high and req_stall low.
//   Result channel rsp_*: a 96-bit mantissa, a scale and a status
//   (ok, too large, too small). One result per input word.
//   A single divide-by-ten unit works one 32-bit limb per cycle, so one pass
//   over the mantissa covers NLIMB limbs (7 at IN_BITS = 224), top limb first.
//   An item first counts its decimal digits (one pass per digit),
//   then divides down to 96 bits and scale 28 (one pass per dropped digit),
//   then rounds, with one more pass when the add-one carries out and the
//   scale is above zero. A zero mantissa goes straight to the result, with
//   its scale capped at 28. After a result is taken the block returns to
//   idle before it takes the next item.
//   The block takes one item at a time: req_stall is low only while idle.
//   The result stays on rsp_* until taken; while rsp_stall is high the
//   result holds and no new item is taken.
//   Reset (synchronous, active high) drops any item in progress and returns
//   the block to idle with no result pending.
module decimal_rescale_round_half_even #(
   parameter int IN_BITS = drrhe_pkg::DEFAULT_IN_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_mant_w0,
   input  logic [63:0] req_mant_w1,
   input  logic [63:0] req_mant_w2,
   input  logic [31:0] req_mant_w3,
   input  logic [7:0]  req_in_scale,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_low,
   output logic [31:0] rsp_out_high,
   output logic [7:0]  rsp_out_scale,
   output logic [1:0]  rsp_status
);
   import drrhe_pkg::*;

   localparam int NLIMB  = (IN_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int W      = NLIMB * LIMB_BITS;
   localparam int IDX_W  = $clog2(NLIMB);
   localparam logic [255:0] IN_MASK = (256'd1 << IN_BITS) - 256'd1;
   localparam logic [IDX_W-1:0] TOP_LIMB = IDX_W'(NLIMB - 1);

   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;
   status_type       status_ff, status_in;
   logic [W-1:0]     mant_ff, mant_in;
   logic [W-1:0]     work_ff, work_in;
   logic [7:0]       scale_ff, scale_in;
   logic [7:0]       s_ff, s_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic             widef_ff, widef_in;
   logic             sticky_ff, sticky_in;
   logic [3:0]       rc_ff, rc_in;
   logic [3:0]       rem_ff, rem_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [255:0]     full_word;
   logic [W-1:0]     in_mant;
   logic [31:0]      limb;
   logic [32:0]      div_n;
   logic [64:0]      div_prod;
   logic [29:0]      div_q;
   logic [32:0]      div_q10;
   logic [3:0]       div_r;
   logic [31:0]      limb_q;
   logic             work_wide;
   logic             work_zero;
   logic             wide_now;
   logic             round_up;
   logic [OUT_BITS:0] inc_sum;

   // Assemble and mask the incoming mantissa
   assign full_word = {32'd0, req_mant_w3, req_mant_w2, req_mant_w1, req_mant_w0} & IN_MASK;
   assign in_mant   = full_word[W-1:0];

   // Divide-by-ten unit: one limb, with the remainder of the limb above
   assign limb     = work_ff[idx_ff*LIMB_BITS +: LIMB_BITS];
   assign div_n    = {1'b0, limb} + (33'(rem_ff) * 33'(LIMB_REM));
   assign div_prod = 65'(div_n) * 65'(RECIP_TEN);
   assign div_q    = div_prod[RECIP_SHIFT +: 30];
   assign div_q10  = {div_q, 3'b000} + {2'b00, div_q, 1'b0};
   assign div_r    = 4'(div_n - div_q10);
   assign limb_q   = 32'(rem_ff * LIMB_QUOT) + {2'b00, div_q};

   // Flags on the working value
   assign work_wide = |work_ff[W-1:OUT_BITS];
   assign work_zero = ~|work_ff;
   assign wide_now  = (cnt_ff == scale_ff) ? work_wide : widef_ff;
   assign round_up  = (rc_ff > HALF_DIGIT) ||
                      ((rc_ff == HALF_DIGIT) && (sticky_ff || work_ff[0]));
   assign inc_sum   = {1'b0, work_ff[OUT_BITS-1:0]} + (OUT_BITS+1)'(1);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      status_in = status_ff;
      mant_in   = mant_ff;
      work_in   = work_ff;
      scale_in  = scale_ff;
      s_in      = s_ff;
      cnt_in    = cnt_ff;
      widef_in  = widef_ff;
      sticky_in = sticky_ff;
      rc_in     = rc_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mant_in   = in_mant;
               work_in   = in_mant;
               scale_in  = req_in_scale;
               cnt_in    = 8'd0;
               widef_in  = 1'b0;
               status_in = STATUS_OK;
               if (~|in_mant) begin
                  s_in     = (req_in_scale > MAX_SCALE) ? MAX_SCALE : req_in_scale;
                  state_in = S_OUT;
               end else begin
                  state_in = S_COUNT;
               end
            end
         end
         S_COUNT: begin
            widef_in = wide_now;
            if (work_zero) begin
               if ({1'b0, scale_ff} > ({1'b0, cnt_ff} + {1'b0, MAX_SCALE})) begin
                  status_in = STATUS_TOO_SMALL;
                  state_in  = S_OUT;
               end else if ((scale_ff <= cnt_ff) && wide_now) begin
                  status_in = STATUS_TOO_LARGE;
                  state_in  = S_OUT;
               end else begin
                  work_in   = mant_ff;
                  s_in      = scale_ff;
                  rc_in     = 4'd0;
                  sticky_in = 1'b0;
                  state_in  = S_REDUCE;
               end
            end else begin
               cnt_in   = cnt_ff + 8'd1;
               idx_in   = TOP_LIMB;
               rem_in   = 4'd0;
               ret_in   = S_COUNT;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            work_in[idx_ff*LIMB_BITS +: LIMB_BITS] = limb_q;
            rem_in = div_r;
            if (idx_ff == '0) begin
               rc_in    = div_r;
               state_in = ret_ff;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         S_REDUCE: begin
            if ((s_ff > MAX_SCALE) || work_wide) begin
               sticky_in = sticky_ff | (rc_ff != 4'd0);
               s_in      = s_ff - 8'd1;
               idx_in    = TOP_LIMB;
               rem_in    = 4'd0;
               ret_in    = S_REDUCE;
               state_in  = S_DIV;
            end else begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_OUT;
            if (!round_up && work_zero) begin
               status_in = STATUS_TOO_SMALL;
            end else if (round_up) begin
               if (inc_sum[OUT_BITS] && (s_ff != 8'd0)) begin
                  // carry out: drop one more digit from the unrounded value
                  s_in     = s_ff - 8'd1;
                  idx_in   = TOP_LIMB;
                  rem_in   = 4'd0;
                  ret_in   = S_FIX;
                  state_in = S_DIV;
               end else if (inc_sum[OUT_BITS]) begin
                  status_in = STATUS_TOO_LARGE;
               end else begin
                  work_in = W'(inc_sum[OUT_BITS-1:0]);
               end
            end
         end
         S_FIX: begin
            work_in  = W'(inc_sum[OUT_BITS-1:0]);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      mant_ff   <= mant_in;
      work_ff   <= work_in;
      scale_ff  <= scale_in;
      s_ff      <= s_in;
      cnt_ff    <= cnt_in;
      widef_ff  <= widef_in;
      sticky_ff <= sticky_in;
      rc_ff     <= rc_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
   end

   // Drive the channels
   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_OUT);
   assign rsp_status    = status_ff;
   assign rsp_out_low   = (status_ff == STATUS_OK) ? work_ff[63:0] : 64'd0;
   assign rsp_out_high  = (status_ff == STATUS_OK) ? work_ff[95:64] : 32'd0;
   assign rsp_out_scale = (status_ff == STATUS_OK) ? s_ff : scale_ff;

endmodule
